// ===== rtl/core/assert_macros.svh =====
// Assertion helpers shared by the likelihood unit. Each expects i_clk and
// i_rst_n in the scope of the module that uses it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The property must hold at every clock edge outside reset.
`define GML_ASSERT_HOLDS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
        else $error(msg);

// When the condition holds, the property must hold in the next cycle.
`define GML_ASSERT_NEXT(lbl, cond, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond) |=> (prop)) \
        else $error(msg);

`endif

// ===== rtl/core/gml_pkg.sv =====
`default_nettype none

package gml_pkg;

    // Default sizes of the component table.
    localparam int unsigned DEF_MAX_COMPONENTS = 16;
    localparam int unsigned DEF_MAX_DIM        = 4;

    // Fixed point format and datapath widths.
    localparam int unsigned FRAC_BITS = 16;
    localparam int unsigned WORD_W    = 32;
    localparam int unsigned COORD_W   = 16;
    localparam int unsigned PROD_W    = 2 * WORD_W;
    localparam int unsigned ACC_W     = PROD_W - FRAC_BITS + 3;
    localparam int unsigned EXP_W     = 31;
    localparam int unsigned EXP_SHIFT = 30;

    // Exponential table geometry.
    localparam int unsigned WHOLE_STEPS = 32;
    localparam int unsigned FRAC_STEPS  = 16;
    localparam int unsigned SEG_W       = 4;
    localparam int unsigned N_W         = 6;

    localparam longint ONE_Q30      = 64'sd1073741824;
    localparam longint HALF_Q30     = 64'sd536870912;
    localparam longint EXP_M1_Q30   = 64'sd395007542;
    localparam longint EXP_M16_Q30  = 64'sd1008687095;

    // Request kinds and word selectors.
    localparam logic       REQ_LOAD  = 1'b0;
    localparam logic       REQ_POINT = 1'b1;
    localparam logic [4:0] SEL_COV_FIRST = 5'd4;
    localparam logic [4:0] SEL_SCALE     = 5'd20;
    localparam logic [4:0] SEL_ENABLE    = 5'd21;

    // Configuration register indexes.
    localparam logic CFG_COUNT = 1'b0;
    localparam logic CFG_DIM   = 1'b1;

    typedef struct packed {
        logic                      req_type;
        logic [3:0]                comp_index;
        logic [4:0]                word_select;
        logic signed [WORD_W-1:0]  word_value;
        logic signed [COORD_W-1:0] coord_0;
        logic signed [COORD_W-1:0] coord_1;
        logic signed [COORD_W-1:0] coord_2;
        logic signed [COORD_W-1:0] coord_3;
    } t_in_item;

    typedef struct packed {
        logic [WORD_W-1:0] likelihood;
        logic              saturated;
    } t_out_item;

    typedef struct packed {
        logic busy;
        logic done;
    } t_seq_status;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_COMP,
        ST_D_RD,
        ST_D_CALC,
        ST_T_RD,
        ST_T_MUL,
        ST_T_ACC,
        ST_Q_MUL,
        ST_Q_ACC,
        ST_H,
        ST_E_DW,
        ST_E_FR,
        ST_E_WM,
        ST_E_SC,
        ST_TERM,
        ST_DONE
    } t_state;

    typedef logic [EXP_W-1:0] t_whole_tab [0:WHOLE_STEPS];
    typedef logic [EXP_W-1:0] t_frac_tab  [0:FRAC_STEPS];
    typedef logic [EXP_W-1:0] t_drop_tab  [0:FRAC_STEPS-1];

    // e^-n in Q1.30 by repeated rounded multiplication.
    function automatic t_whole_tab build_whole();
        t_whole_tab tab;
        longint     v;
        v = ONE_Q30;
        for (int k = 0; k <= WHOLE_STEPS; k++) begin
            tab[k] = EXP_W'(v);
            v = (v * EXP_M1_Q30 + HALF_Q30) >>> EXP_SHIFT;
        end
        return tab;
    endfunction

    // e^(-k/16) in Q1.30.
    function automatic t_frac_tab build_frac();
        t_frac_tab tab;
        longint    v;
        v = ONE_Q30;
        for (int k = 0; k <= FRAC_STEPS; k++) begin
            tab[k] = EXP_W'(v);
            v = (v * EXP_M16_Q30 + HALF_Q30) >>> EXP_SHIFT;
        end
        return tab;
    endfunction

    // Step between neighbouring fraction entries, used for interpolation.
    function automatic t_drop_tab build_drop();
        t_frac_tab f;
        t_drop_tab tab;
        f = build_frac();
        for (int k = 0; k < FRAC_STEPS; k++) begin
            tab[k] = f[k] - f[k+1];
        end
        return tab;
    endfunction

    localparam t_whole_tab WHOLE_EXP = build_whole();
    localparam t_frac_tab  FRAC_EXP  = build_frac();
    localparam t_drop_tab  FRAC_DROP = build_drop();

    // Saturate an accumulator value to a signed 32-bit word.
    function automatic logic signed [WORD_W-1:0] sat32(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        hi = ACC_W'(64'sh7FFF_FFFF);
        lo = ACC_W'(-64'sh8000_0000);
        if (v > hi) begin
            return WORD_W'(hi);
        end else if (v < lo) begin
            return WORD_W'(lo);
        end
        return WORD_W'(v);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/gaussian_mixture_likelihood_unit.sv =====
`default_nettype none
// Gaussian mixture likelihood unit.
// Input channel (i_in_valid / o_in_stall, payload i_in_data): a transfer
// with req_type 0 writes one model word (mean, inverse covariance, scale
// or enable) of one component and gives no result. A transfer with
// req_type 1 evaluates a point and gives one result on the output
// channel (o_out_valid / i_out_stall, payload o_out_data).
// Configuration (i_cfg_valid / o_cfg_ready, index and data) sets the
// component count and the dimension; write it only while the unit is idle.
// A point runs on one shared multiplier under a sequencer that takes the
// enabled components in turn and passes over the disabled ones; a
// component whose quadratic form is out of range adds no term.
// The input is stalled while a point is being evaluated.
// The result sits in an output register; while the receiver stalls it is
// held and a finished evaluation waits for it to be taken.
// Reset clears the enable bits and sets count 0, dimension 2; the other
// tables hold nothing defined until written.

module gaussian_mixture_likelihood_unit #(
    parameter int unsigned MAX_COMPONENTS = gml_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_DIM        = gml_pkg::DEF_MAX_DIM
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    input  wire logic                i_in_valid,
    output logic                     o_in_stall,
    input  wire gml_pkg::t_in_item   i_in_data,
    output logic                     o_out_valid,
    input  wire logic                i_out_stall,
    output gml_pkg::t_out_item       o_out_data,
    input  wire logic                i_cfg_valid,
    output logic                     o_cfg_ready,
    input  wire logic                i_cfg_index,
    input  wire logic [7:0]          i_cfg_data
);
    import gml_pkg::*;

    localparam int unsigned MEAN_D = MAX_COMPONENTS * MAX_DIM;
    localparam int unsigned COV_D  = MEAN_D * MAX_DIM;
    localparam int unsigned MA_W   = (MEAN_D > 1) ? $clog2(MEAN_D) : 1;
    localparam int unsigned CA_W   = (COV_D > 1) ? $clog2(COV_D) : 1;
    localparam int unsigned CI_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1;

    logic [4:0]                r_count;
    logic [2:0]                r_dim;
    logic                      r_out_valid;
    t_out_item                 r_out;
    t_seq_status               status;
    t_out_item                 result;
    logic                      in_xfer;
    logic                      out_free;
    logic [MA_W-1:0]           mean_addr;
    logic [CA_W-1:0]           cov_addr;
    logic [CI_W-1:0]           scale_addr;
    logic signed [WORD_W-1:0]  mean_q;
    logic signed [WORD_W-1:0]  cov_q;
    logic signed [WORD_W-1:0]  scale_q;
    logic [MAX_COMPONENTS-1:0] en;

    assign in_xfer     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_in_stall  = status.busy;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // Configuration registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
            r_dim   <= 3'd2;
        end else if (i_cfg_valid && o_cfg_ready) begin
            if (i_cfg_index == CFG_COUNT) begin
                r_count <= i_cfg_data[4:0];
            end
            if (i_cfg_index == CFG_DIM) begin
                r_dim <= i_cfg_data[2:0];
            end
        end
    end

    // Output register: loaded when a result is finished, freed on transfer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (status.done) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (status.done) begin
            r_out <= result;
        end
    end

    gml_store #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_DIM        (MAX_DIM)
    ) u_store (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_wr         (in_xfer && (i_in_data.req_type == REQ_LOAD)),
        .i_item       (i_in_data),
        .i_mean_addr  (mean_addr),
        .i_cov_addr   (cov_addr),
        .i_scale_addr (scale_addr),
        .o_mean       (mean_q),
        .o_cov        (cov_q),
        .o_scale      (scale_q),
        .o_en         (en)
    );

    gml_seq #(
        .MAX_COMPONENTS (MAX_COMPONENTS),
        .MAX_DIM        (MAX_DIM)
    ) u_seq (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_start      (in_xfer && (i_in_data.req_type == REQ_POINT)),
        .i_item       (i_in_data),
        .i_count      (r_count),
        .i_dim        (r_dim),
        .i_out_free   (out_free),
        .i_mean       (mean_q),
        .i_cov        (cov_q),
        .i_scale      (scale_q),
        .i_en         (en),
        .o_mean_addr  (mean_addr),
        .o_cov_addr   (cov_addr),
        .o_scale_addr (scale_addr),
        .o_status     (status),
        .o_result     (result)
    );

endmodule

`default_nettype wire

// ===== rtl/core/gml_mul.sv =====
`default_nettype none

module gml_mul (
    input  wire logic                                  i_clk,
    input  wire logic signed [gml_pkg::WORD_W-1:0]     i_a,
    input  wire logic signed [gml_pkg::WORD_W-1:0]     i_b,
    output logic signed [gml_pkg::PROD_W-1:0]          o_prod
);
    import gml_pkg::*;

    logic signed [PROD_W-1:0] r_prod;

    // Shared signed multiplier with its product registered.
    always_ff @(posedge i_clk) begin
        r_prod <= PROD_W'(i_a) * PROD_W'(i_b);
    end

    assign o_prod = r_prod;

endmodule

`default_nettype wire

// ===== rtl/core/gml_store.sv =====
`default_nettype none

module gml_store #(
    parameter int unsigned MAX_COMPONENTS = gml_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_DIM        = gml_pkg::DEF_MAX_DIM,
    localparam int unsigned MEAN_D = MAX_COMPONENTS * MAX_DIM,
    localparam int unsigned COV_D  = MEAN_D * MAX_DIM,
    localparam int unsigned MA_W   = (MEAN_D > 1) ? $clog2(MEAN_D) : 1,
    localparam int unsigned CA_W   = (COV_D > 1) ? $clog2(COV_D) : 1,
    localparam int unsigned CI_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_wr,
    input  wire gml_pkg::t_in_item                 i_item,
    input  wire logic [MA_W-1:0]                   i_mean_addr,
    input  wire logic [CA_W-1:0]                   i_cov_addr,
    input  wire logic [CI_W-1:0]                   i_scale_addr,
    output logic signed [gml_pkg::WORD_W-1:0]      o_mean,
    output logic signed [gml_pkg::WORD_W-1:0]      o_cov,
    output logic signed [gml_pkg::WORD_W-1:0]      o_scale,
    output logic [MAX_COMPONENTS-1:0]              o_en
);
    import gml_pkg::*;

    logic signed [WORD_W-1:0] mean_mem  [0:MEAN_D-1];
    logic signed [WORD_W-1:0] cov_mem   [0:COV_D-1];
    logic signed [WORD_W-1:0] scale_mem [0:MAX_COMPONENTS-1];
    logic [MAX_COMPONENTS-1:0] r_en;
    logic signed [WORD_W-1:0] r_mean;
    logic signed [WORD_W-1:0] r_cov;
    logic signed [WORD_W-1:0] r_scale;

    logic            comp_ok;
    logic            mean_we;
    logic            cov_we;
    logic            scale_we;
    logic            en_we;
    logic [4:0]      cov_off;
    logic [2:0]      cov_row;
    logic [2:0]      cov_col;
    logic [MA_W-1:0] mean_wa;
    logic [CA_W-1:0] cov_wa;
    logic [CI_W-1:0] comp_wa;

    // Decode of a load transfer into one table write.
    always_comb begin
        comp_ok  = int'(i_item.comp_index) < MAX_COMPONENTS;
        cov_off  = i_item.word_select - SEL_COV_FIRST;
        cov_row  = 3'(cov_off[3:2]);
        cov_col  = 3'(cov_off[1:0]);
        mean_we  = i_wr && comp_ok && (i_item.word_select < SEL_COV_FIRST)
                   && (int'(i_item.word_select) < MAX_DIM);
        cov_we   = i_wr && comp_ok && (i_item.word_select >= SEL_COV_FIRST)
                   && (i_item.word_select < SEL_SCALE)
                   && (int'(cov_row) < MAX_DIM) && (int'(cov_col) < MAX_DIM);
        scale_we = i_wr && comp_ok && (i_item.word_select == SEL_SCALE);
        en_we    = i_wr && comp_ok && (i_item.word_select == SEL_ENABLE);
        mean_wa  = MA_W'(int'(i_item.comp_index) * MAX_DIM + int'(i_item.word_select));
        cov_wa   = CA_W'((int'(i_item.comp_index) * MAX_DIM + int'(cov_row)) * MAX_DIM
                         + int'(cov_col));
        comp_wa  = CI_W'(i_item.comp_index);
    end

    // Table memories: one write port from loads, one registered read port.
    always_ff @(posedge i_clk) begin
        if (mean_we) begin
            mean_mem[mean_wa] <= i_item.word_value;
        end
        if (cov_we) begin
            cov_mem[cov_wa] <= i_item.word_value;
        end
        if (scale_we) begin
            scale_mem[comp_wa] <= i_item.word_value;
        end
        r_mean  <= mean_mem[i_mean_addr];
        r_cov   <= cov_mem[i_cov_addr];
        r_scale <= scale_mem[i_scale_addr];
    end

    // Enable bits are cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_en <= '0;
        end else if (en_we) begin
            r_en[comp_wa] <= i_item.word_value[0];
        end
    end

    assign o_mean  = r_mean;
    assign o_cov   = r_cov;
    assign o_scale = r_scale;
    assign o_en    = r_en;

endmodule

`default_nettype wire

// ===== rtl/core/gml_seq.sv =====
`default_nettype none
`include "assert_macros.svh"

module gml_seq #(
    parameter int unsigned MAX_COMPONENTS = gml_pkg::DEF_MAX_COMPONENTS,
    parameter int unsigned MAX_DIM        = gml_pkg::DEF_MAX_DIM,
    localparam int unsigned MEAN_D = MAX_COMPONENTS * MAX_DIM,
    localparam int unsigned COV_D  = MEAN_D * MAX_DIM,
    localparam int unsigned MA_W   = (MEAN_D > 1) ? $clog2(MEAN_D) : 1,
    localparam int unsigned CA_W   = (COV_D > 1) ? $clog2(COV_D) : 1,
    localparam int unsigned CI_W   = (MAX_COMPONENTS > 1) ? $clog2(MAX_COMPONENTS) : 1
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_start,
    input  wire gml_pkg::t_in_item                 i_item,
    input  wire logic [4:0]                        i_count,
    input  wire logic [2:0]                        i_dim,
    input  wire logic                              i_out_free,
    input  wire logic signed [gml_pkg::WORD_W-1:0] i_mean,
    input  wire logic signed [gml_pkg::WORD_W-1:0] i_cov,
    input  wire logic signed [gml_pkg::WORD_W-1:0] i_scale,
    input  wire logic [MAX_COMPONENTS-1:0]         i_en,
    output logic [MA_W-1:0]                        o_mean_addr,
    output logic [CA_W-1:0]                        o_cov_addr,
    output logic [CI_W-1:0]                        o_scale_addr,
    output gml_pkg::t_seq_status                   o_status,
    output gml_pkg::t_out_item                     o_result
);
    import gml_pkg::*;

    localparam int unsigned CC_W  = $clog2(MAX_COMPONENTS + 1);
    localparam int unsigned DI_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
    localparam int unsigned SUM_W = WORD_W + 2 + $clog2(MAX_COMPONENTS + 1);

    t_state                    r_state;
    t_state                    n_state;
    logic [CC_W-1:0]           r_c;
    logic [CC_W-1:0]           r_count;
    logic [DI_W-1:0]           r_i;
    logic [DI_W-1:0]           r_j;
    logic [DI_W-1:0]           r_dim_last;
    logic signed [COORD_W-1:0] r_coord [0:3];
    logic signed [WORD_W-1:0]  r_d [0:MAX_DIM-1];
    logic signed [ACC_W-1:0]   r_t;
    logic signed [ACC_W-1:0]   r_q;
    logic [N_W-1:0]            r_n;
    logic [SEG_W-1:0]          r_seg;
    logic [FRAC_BITS-1:0]      r_w;
    logic                      r_skip;
    logic [EXP_W-1:0]          r_fr;
    logic signed [SUM_W-1:0]   r_sum;

    logic signed [WORD_W-1:0]  mul_a;
    logic signed [WORD_W-1:0]  mul_b;
    logic signed [PROD_W-1:0]  prod;
    logic signed [ACC_W-1:0]   prod_sh;
    logic signed [ACC_W-1:0]   diff;
    logic signed [ACC_W-1:0]   h_raw;
    logic signed [ACC_W-1:0]   h_pos;
    logic [FRAC_BITS-1:0]      h_frac;
    logic                      comp_end;
    logic                      i_last;
    logic                      j_last;
    logic                      comp_on;
    logic [CC_W-1:0]           count_eff;
    logic [DI_W-1:0]           dim_last_eff;

    gml_mul u_mul (
        .i_clk  (i_clk),
        .i_a    (mul_a),
        .i_b    (mul_b),
        .o_prod (prod)
    );

    // Shared decodes of counters and the multiplier result.
    always_comb begin
        comp_end = r_c >= r_count;
        comp_on  = i_en[CI_W'(r_c)];
        i_last   = r_i == r_dim_last;
        j_last   = r_j == r_dim_last;
        prod_sh  = ACC_W'(prod >>> FRAC_BITS);
        diff     = (ACC_W'(r_coord[2'(r_i)]) <<< FRAC_BITS) - ACC_W'(i_mean);
        h_raw    = r_q >>> 1;
        h_pos    = h_raw[ACC_W-1] ? '0 : h_raw;
        h_frac   = h_pos[FRAC_BITS-1:0];
        if (int'(i_count) > MAX_COMPONENTS) begin
            count_eff = CC_W'(MAX_COMPONENTS);
        end else begin
            count_eff = CC_W'(i_count);
        end
        if (i_dim == 3'd0) begin
            dim_last_eff = '0;
        end else if (int'(i_dim) > MAX_DIM) begin
            dim_last_eff = DI_W'(MAX_DIM - 1);
        end else begin
            dim_last_eff = DI_W'(i_dim - 3'd1);
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE:   if (i_start) n_state = ST_COMP;
            ST_COMP: begin
                if (comp_end) begin
                    n_state = ST_DONE;
                end else if (comp_on) begin
                    n_state = ST_D_RD;
                end
            end
            ST_D_RD:   n_state = ST_D_CALC;
            ST_D_CALC: n_state = i_last ? ST_T_RD : ST_D_RD;
            ST_T_RD:   n_state = ST_T_MUL;
            ST_T_MUL:  n_state = ST_T_ACC;
            ST_T_ACC:  n_state = j_last ? ST_Q_MUL : ST_T_RD;
            ST_Q_MUL:  n_state = ST_Q_ACC;
            ST_Q_ACC:  n_state = i_last ? ST_H : ST_T_RD;
            ST_H:      n_state = ST_E_DW;
            ST_E_DW:   n_state = r_skip ? ST_COMP : ST_E_FR;
            ST_E_FR:   n_state = ST_E_WM;
            ST_E_WM:   n_state = ST_E_SC;
            ST_E_SC:   n_state = ST_TERM;
            ST_TERM:   n_state = ST_COMP;
            ST_DONE:   if (i_out_free) n_state = ST_IDLE;
            default:   n_state = ST_IDLE;
        endcase
    end

    // Outputs: multiplier operands, table addresses, status and the result.
    always_comb begin
        mul_a = '0;
        mul_b = '0;
        unique case (r_state)
            ST_T_MUL: begin
                mul_a = i_cov;
                mul_b = r_d[r_j];
            end
            ST_Q_MUL: begin
                mul_a = r_d[r_i];
                mul_b = sat32(r_t);
            end
            ST_E_DW: begin
                mul_a = WORD_W'(FRAC_DROP[r_seg]);
                mul_b = WORD_W'(r_w);
            end
            ST_E_WM: begin
                mul_a = WORD_W'(WHOLE_EXP[r_n]);
                mul_b = WORD_W'(r_fr);
            end
            ST_E_SC: begin
                mul_a = i_scale;
                mul_b = WORD_W'(prod[EXP_SHIFT +: EXP_W]);
            end
            default: begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        o_mean_addr   = MA_W'(int'(r_c) * MAX_DIM + int'(r_i));
        o_cov_addr    = CA_W'((int'(r_c) * MAX_DIM + int'(r_i)) * MAX_DIM + int'(r_j));
        o_scale_addr  = CI_W'(r_c);
        o_status.busy = r_state != ST_IDLE;
        o_status.done = (r_state == ST_DONE) && i_out_free;
        if (r_sum[SUM_W-1]) begin
            o_result.likelihood = '0;
            o_result.saturated  = 1'b1;
        end else if (r_sum[SUM_W-2:WORD_W] != '0) begin
            o_result.likelihood = '1;
            o_result.saturated  = 1'b1;
        end else begin
            o_result.likelihood = r_sum[WORD_W-1:0];
            o_result.saturated  = 1'b0;
        end
    end

    // Sequencer registers and the datapath they steer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_c        <= '0;
            r_count    <= '0;
            r_i        <= '0;
            r_j        <= '0;
            r_dim_last <= '0;
        end else begin
            r_state <= n_state;
            unique case (r_state)
                ST_IDLE: begin
                    if (i_start) begin
                        r_c        <= '0;
                        r_i        <= '0;
                        r_j        <= '0;
                        r_count    <= count_eff;
                        r_dim_last <= dim_last_eff;
                        r_sum      <= '0;
                        r_coord[0] <= i_item.coord_0;
                        r_coord[1] <= i_item.coord_1;
                        r_coord[2] <= i_item.coord_2;
                        r_coord[3] <= i_item.coord_3;
                    end
                end
                ST_COMP: begin
                    r_i <= '0;
                    r_j <= '0;
                    if (!comp_end && !comp_on) begin
                        r_c <= r_c + 1'b1;
                    end
                end
                ST_D_CALC: begin
                    r_d[r_i] <= sat32(diff);
                    r_t      <= '0;
                    r_q      <= '0;
                    r_i      <= i_last ? '0 : r_i + 1'b1;
                end
                ST_T_ACC: begin
                    r_t <= r_t + prod_sh;
                    if (!j_last) begin
                        r_j <= r_j + 1'b1;
                    end
                end
                ST_Q_ACC: begin
                    r_q <= r_q + prod_sh;
                    r_t <= '0;
                    r_j <= '0;
                    if (!i_last) begin
                        r_i <= r_i + 1'b1;
                    end
                end
                ST_H: begin
                    r_skip <= h_pos > (ACC_W'(WHOLE_STEPS) <<< FRAC_BITS);
                    r_n    <= h_pos[FRAC_BITS +: N_W];
                    r_seg  <= h_frac[FRAC_BITS-1 -: SEG_W];
                    r_w    <= {h_frac[FRAC_BITS-SEG_W-1:0], SEG_W'(0)};
                end
                ST_E_DW: begin
                    if (r_skip) begin
                        r_c <= r_c + 1'b1;
                    end
                end
                ST_E_FR: begin
                    r_fr <= FRAC_EXP[r_seg] - prod[FRAC_BITS +: EXP_W];
                end
                ST_TERM: begin
                    r_sum <= r_sum + SUM_W'($signed(prod[EXP_SHIFT +: WORD_W]));
                    r_c   <= r_c + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    `GML_ASSERT_NEXT(a_comp_end_done, (r_state == ST_COMP) && (r_c >= r_count), r_state == ST_DONE, "component scan did not finish")
    `GML_ASSERT_HOLDS(a_comp_in_range, (r_state == ST_IDLE) || (r_c <= r_count), "component index ran past the count")
    `GML_ASSERT_HOLDS(a_elem_in_range, (r_state == ST_IDLE) || ((r_i <= r_dim_last) && (r_j <= r_dim_last)), "element index ran past the dimension")

endmodule

`default_nettype wire
